FILE: rtl/fqks_pkg.sv
`timescale 1ns / 1ps
package fqks_pkg;
    localparam int DEPTH    = 128;
    localparam int KEY_BITS = 64;
    localparam int AW       = $clog2(DEPTH);
    localparam int CW       = AW + 1;
    localparam int REC_W    = KEY_BITS + 16 + 8 + 14;

    typedef enum logic [1:0] {
        FN_ENQ  = 2'd0,
        FN_DEQ  = 2'd1,
        FN_LIN  = 2'd2,
        FN_SORT = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_DEQ_RD, S_LIN_RD, S_LIN_CHK, S_SRT_RDI, S_SRT_RDJ, S_SRT_CMP,
        S_SRT_WRJ, S_BIN_RD, S_BIN_CHK, S_OUT
    } t_state;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [15:0]         prog;
        logic [7:0]          pass;
        logic [13:0]         avg;
    } t_rec;

    typedef struct packed {
        logic        we;
        logic [AW-1:0] waddr;
        t_rec        wdata;
        logic [AW-1:0] raddr;
    } t_mem_req;
endpackage

FILE: rtl/fqks_if.sv
`timescale 1ns / 1ps
interface fqks_in_if import fqks_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [63:0] name_key;
    logic [15:0] program_code;
    logic [7:0]  passed_count;
    logic [13:0] grade_average;
    modport source (output valid, func, name_key, program_code, passed_count,
                    grade_average, input ready);
    modport sink (input valid, func, name_key, program_code, passed_count,
                  grade_average, output ready);
endinterface

interface fqks_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [6:0]  position;
    logic [63:0] out_key;
    logic [15:0] out_program;
    logic [7:0]  out_passed;
    logic [13:0] out_average;
    modport source (output valid, status, position, out_key, out_program, out_passed,
                    out_average, input ready);
    modport sink (input valid, status, position, out_key, out_program, out_passed,
                  out_average, output ready);
endinterface

FILE: rtl/fqks_ram.sv
`timescale 1ns / 1ps
module fqks_ram
    import fqks_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_rec     o_rdata
);
    // Record store, one write and one registered read per cycle.
    t_rec r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end
endmodule

FILE: rtl/fqks_ctrl.sv
`timescale 1ns / 1ps
module fqks_ctrl
    import fqks_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    fqks_in_if.sink   in_ch,
    fqks_out_if.source out_ch,
    output t_mem_req  o_req,
    input  t_rec      i_rdata
);
    t_state r_state, n_state;
    logic [CW-1:0] r_head, r_tail, n_head, n_tail;
    logic [CW-1:0] r_i, r_j, n_i, n_j;
    logic signed [CW+1:0] r_lo, r_hi, n_lo, n_hi;
    logic [KEY_BITS-1:0] r_key, n_key;
    t_rec r_reci, n_reci, r_recj, n_recj;
    logic [1:0] r_st, n_st;
    logic [6:0] r_pos, n_pos;
    t_rec r_orec, n_orec;
    logic signed [CW+1:0] w_mid;
    logic [CW-1:0] w_midu;
    logic w_acc;

    assign w_acc = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (r_state == S_IDLE);
    assign w_mid = (r_lo + r_hi) >>> 1;
    assign w_midu = w_mid[CW-1:0];

    // Registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head <= '0;
            r_tail <= '0;
        end else begin
            r_state <= n_state;
            r_head <= n_head;
            r_tail <= n_tail;
        end
        r_i <= n_i; r_j <= n_j; r_lo <= n_lo; r_hi <= n_hi;
        r_key <= n_key; r_reci <= n_reci; r_recj <= n_recj;
        r_st <= n_st; r_pos <= n_pos; r_orec <= n_orec;
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_acc) begin
                unique case (t_func'(in_ch.func))
                    FN_ENQ:  n_state = S_OUT;
                    FN_DEQ:  n_state = (r_head == r_tail) ? S_OUT : S_DEQ_RD;
                    FN_LIN:  n_state = (r_head == r_tail) ? S_OUT : S_LIN_RD;
                    default: n_state = (r_tail > r_head + 1'b1) ? S_SRT_RDI : S_BIN_RD;
                endcase
            end
            S_DEQ_RD:  n_state = S_OUT;
            S_LIN_RD:  n_state = S_LIN_CHK;
            S_LIN_CHK: if (i_rdata.key == r_key || r_i + 1'b1 >= r_tail) n_state = S_OUT;
                       else n_state = S_LIN_RD;
            S_SRT_RDI: n_state = S_SRT_RDJ;
            S_SRT_RDJ: n_state = S_SRT_CMP;
            S_SRT_CMP: n_state = (i_rdata.key < r_reci.key) ? S_SRT_WRJ : S_SRT_RDJ;
            S_SRT_WRJ: n_state = S_SRT_RDJ;
            S_BIN_RD:  n_state = (r_lo <= r_hi) ? S_BIN_CHK : S_OUT;
            S_BIN_CHK: n_state = (i_rdata.key == r_key) ? S_OUT : S_BIN_RD;
            S_OUT:     if (out_ch.ready) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
        // End of a sort row or of the whole sort.
        if ((r_state == S_SRT_CMP && !(i_rdata.key < r_reci.key)) ||
            r_state == S_SRT_WRJ) begin
            if (r_j + 1'b1 >= r_tail) begin
                n_state = (r_i + 2'd2 >= r_tail) ? S_BIN_RD : S_SRT_RDI;
            end
        end
    end

    // Datapath and memory requests.
    always_comb begin
        n_head = r_head; n_tail = r_tail; n_i = r_i; n_j = r_j;
        n_lo = r_lo; n_hi = r_hi; n_key = r_key;
        n_reci = r_reci; n_recj = r_recj; n_st = r_st; n_pos = r_pos; n_orec = r_orec;
        o_req = '0;
        unique case (r_state)
            S_IDLE: if (w_acc) begin
                n_key = in_ch.name_key[KEY_BITS-1:0];
                n_st = ST_OK; n_pos = '0; n_orec = '0;
                n_i = r_head; n_j = r_head + 1'b1;
                n_lo = $signed({2'b00, r_head});
                n_hi = (CW+2)'($signed({2'b00, r_tail}) - 1);
                o_req.raddr = r_head[AW-1:0];
                unique case (t_func'(in_ch.func))
                    FN_ENQ: if (r_tail >= CW'(DEPTH)) n_st = ST_FULL;
                        else begin
                            o_req.we = 1'b1;
                            o_req.waddr = r_tail[AW-1:0];
                            o_req.wdata = '{in_ch.name_key[KEY_BITS-1:0], in_ch.program_code,
                                            in_ch.passed_count, in_ch.grade_average};
                            n_tail = r_tail + 1'b1;
                        end
                    FN_DEQ: if (r_head == r_tail) n_st = ST_EMPTY;
                    FN_LIN: if (r_head == r_tail) n_st = ST_MISSING;
                    default: n_st = ST_MISSING;
                endcase
            end
            S_DEQ_RD: begin
                n_orec = i_rdata;
                if (r_head + 1'b1 == r_tail) begin
                    n_head = '0; n_tail = '0;
                end else n_head = r_head + 1'b1;
            end
            S_LIN_RD: o_req.raddr = r_i[AW-1:0];
            S_LIN_CHK: begin
                if (i_rdata.key == r_key) n_pos = 7'(r_i - r_head);
                else if (r_i + 1'b1 >= r_tail) n_st = ST_MISSING;
                n_i = r_i + 1'b1;
            end
            S_SRT_RDI: begin
                o_req.raddr = r_i[AW-1:0];
                n_j = r_i + 1'b1;
            end
            S_SRT_RDJ: begin
                if (r_j == r_i + 1'b1) n_reci = i_rdata;
                o_req.raddr = r_j[AW-1:0];
            end
            S_SRT_CMP: if (i_rdata.key < r_reci.key) begin
                // Swap: slot i takes slot j, the held record goes to j next.
                o_req.we = 1'b1; o_req.waddr = r_i[AW-1:0]; o_req.wdata = i_rdata;
                n_recj = r_reci; n_reci = i_rdata;
            end else begin
                n_j = r_j + 1'b1;
                if (r_j + 1'b1 >= r_tail) n_i = r_i + 1'b1;
                o_req.raddr = n_j[AW-1:0];
            end
            S_SRT_WRJ: begin
                o_req.we = 1'b1; o_req.waddr = r_j[AW-1:0]; o_req.wdata = r_recj;
                n_j = r_j + 1'b1;
                if (r_j + 1'b1 >= r_tail) n_i = r_i + 1'b1;
            end
            S_BIN_RD: o_req.raddr = w_midu[AW-1:0];
            S_BIN_CHK: begin
                if (i_rdata.key == r_key) begin
                    n_st = ST_OK; n_pos = 7'(w_midu - r_head);
                end else if (i_rdata.key < r_key) n_lo = (CW+2)'(w_mid + 1);
                else n_hi = (CW+2)'(w_mid - 1);
            end
            default: ;
        endcase
        // Within a row, slot j is read again after the held record is loaded.
        if (r_state == S_SRT_RDJ && r_j != r_i + 1'b1) o_req.raddr = r_j[AW-1:0];
    end

    // Result channel, driven from the registered result.
    assign out_ch.valid = (r_state == S_OUT);
    assign out_ch.status = r_st;
    assign out_ch.position = r_pos;
    assign out_ch.out_key = 64'(r_orec.key);
    assign out_ch.out_program = r_orec.prog;
    assign out_ch.out_passed = r_orec.pass;
    assign out_ch.out_average = r_orec.avg;
endmodule

FILE: rtl/fifo_queue_with_key_search_unit.sv
`timescale 1ns / 1ps
// Channel | Dir | Payload
// in_ch   | in  | func, name_key, program_code, passed_count, grade_average
// out_ch  | out | status, position, out_key, out_program, out_passed, out_average
// Enqueue writes on acceptance, dequeue reads the head record, and linear search
// reads entries until a match. Sort then search makes n*(n-1)/2 compares over
// one record memory with one read and one write port, then one read per binary probe.
// Reset clears the head and tail indices and the controller, not the memory.
// One item at a time; a waiting result holds off the next item.
module fifo_queue_with_key_search_unit
    import fqks_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    fqks_in_if.sink    in_ch,
    fqks_out_if.source out_ch
);
    t_mem_req w_req;
    t_rec     w_rdata;

    fqks_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .o_req(w_req), .i_rdata(w_rdata)
    );

    fqks_ram u_ram (.i_clk(i_clk), .i_req(w_req), .o_rdata(w_rdata));

`ifndef SYNTHESIS
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_ch.ready && out_ch.valid)) else $error("ready while result pending");
    a_dq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && out_ch.status != ST_OK |-> out_ch.out_key == '0)
        else $error("payload on failed item");
`endif
endmodule

FILE: test/tb_fifo_queue_with_key_search_unit.sv
`timescale 1ns / 1ps
module tb_fifo_queue_with_key_search_unit;
    import fqks_pkg::*;

    typedef struct {
        t_func       func;
        logic [63:0] key;
        logic [15:0] prog;
        logic [7:0]  pass;
        logic [13:0] avg;
        bit          drain_first;
    } t_request;

    typedef struct {
        t_status     status;
        logic [6:0]  position;
        logic [63:0] key;
        logic [15:0] prog;
        logic [7:0]  pass;
        logic [13:0] avg;
    } t_reply;

    localparam int IDLE_LIMIT = 200000;

    logic clk;
    logic rst_n;

    fqks_in_if  in_ch();
    fqks_out_if out_ch();

    fifo_queue_with_key_search_unit u_top (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Shadow copy of the queue contents.
    t_rec     shadow_mem [DEPTH];
    int       shadow_head;
    int       shadow_tail;

    t_request pending_requests[$];
    t_reply   expected_replies[$];
    int       errors;
    int       idle_cycles;
    int       gap_left;
    int       stall_left;
    bit       quiet;
    bit       long_hold_req;
    bit       in_fired;

    // Computes the reply to one request and updates the shadow queue.
    function automatic t_reply queue_reply(t_request r);
        t_reply rep;
        t_rec   tmp;
        int     lo;
        int     hi;
        int     mid;
        rep = '{ST_OK, 7'd0, 64'd0, 16'd0, 8'd0, 14'd0};
        case (r.func)
            FN_ENQ: begin
                if (shadow_tail >= DEPTH) begin
                    rep.status = ST_FULL;
                end else begin
                    shadow_mem[shadow_tail] = '{r.key, r.prog, r.pass, r.avg};
                    shadow_tail++;
                end
            end
            FN_DEQ: begin
                if (shadow_head == shadow_tail) begin
                    rep.status = ST_EMPTY;
                end else begin
                    rep.key  = shadow_mem[shadow_head].key;
                    rep.prog = shadow_mem[shadow_head].prog;
                    rep.pass = shadow_mem[shadow_head].pass;
                    rep.avg  = shadow_mem[shadow_head].avg;
                    shadow_head++;
                    if (shadow_head == shadow_tail) begin
                        shadow_head = 0;
                        shadow_tail = 0;
                    end
                end
            end
            FN_LIN: begin
                rep.status = ST_MISSING;
                for (int i = shadow_head; i < shadow_tail; i++) begin
                    if (shadow_mem[i].key == r.key) begin
                        rep.status   = ST_OK;
                        rep.position = 7'(i - shadow_head);
                        break;
                    end
                end
            end
            default: begin
                // Exchange sort of the live entries, whole records move.
                for (int i = shadow_head; i + 1 < shadow_tail; i++) begin
                    for (int j = i + 1; j < shadow_tail; j++) begin
                        if (shadow_mem[j].key < shadow_mem[i].key) begin
                            tmp           = shadow_mem[i];
                            shadow_mem[i] = shadow_mem[j];
                            shadow_mem[j] = tmp;
                        end
                    end
                end
                rep.status = ST_MISSING;
                lo = shadow_head;
                hi = shadow_tail - 1;
                while (lo <= hi) begin
                    mid = (lo + hi) / 2;
                    if (shadow_mem[mid].key == r.key) begin
                        rep.status   = ST_OK;
                        rep.position = 7'(mid - shadow_head);
                        break;
                    end else if (shadow_mem[mid].key < r.key) begin
                        lo = mid + 1;
                    end else begin
                        hi = mid - 1;
                    end
                end
            end
        endcase
        return rep;
    endfunction

    function automatic void add_request(t_func f, logic [63:0] k, logic [15:0] p,
                                        logic [7:0] c, logic [13:0] a, bit drain);
        t_request r;
        r = '{f, k, p, c, a, drain};
        pending_requests.push_back(r);
    endfunction

    // Clock.
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Sender: presents items at the falling edge, with random gaps.
    always @(negedge clk) begin
        t_request    r;
        logic        nxt_valid;
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_fired) begin
            // The item on the channel waits for acceptance.
        end else begin
            in_fired = 1'b0;
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                gap_left = $urandom_range(1, 11) - 1;
            end else if (pending_requests.size() > 0 &&
                         (!pending_requests[0].drain_first ||
                          (expected_replies.size() == 0 && !out_ch.valid))) begin
                r = pending_requests.pop_front();
                in_ch.func          <= r.func;
                in_ch.name_key      <= r.key;
                in_ch.program_code  <= r.prog;
                in_ch.passed_count  <= r.pass;
                in_ch.grade_average <= r.avg;
                nxt_valid = 1'b1;
            end
            in_ch.valid <= nxt_valid;
        end
    end

    // Receiver: random stall bursts plus one long hold-off.
    always @(negedge clk) begin
        logic nxt_ready;
        nxt_ready = 1'b1;
        if (!rst_n) begin
            nxt_ready = 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left = 400;
            nxt_ready = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            nxt_ready = 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            nxt_ready = 1'b0;
        end
        out_ch.ready <= nxt_ready;
    end

    // Monitor: predicts accepted items and checks accepted results.
    always @(posedge clk) begin
        t_request r;
        t_reply   exp_r;
        if (rst_n) begin
            idle_cycles++;
            if (out_ch.valid && out_ch.ready) begin
                idle_cycles = 0;
                if (expected_replies.size() == 0) begin
                    $error("result with no expectation waiting");
                    errors++;
                end else begin
                    exp_r = expected_replies.pop_front();
                    if (out_ch.status !== exp_r.status) begin
                        $error("status: expected %0d actual %0d", exp_r.status, out_ch.status);
                        errors++;
                    end
                    if (out_ch.position !== exp_r.position) begin
                        $error("position: expected %0d actual %0d",
                               exp_r.position, out_ch.position);
                        errors++;
                    end
                    if (out_ch.out_key !== exp_r.key) begin
                        $error("out_key: expected %h actual %h", exp_r.key, out_ch.out_key);
                        errors++;
                    end
                    if (out_ch.out_program !== exp_r.prog) begin
                        $error("out_program: expected %h actual %h",
                               exp_r.prog, out_ch.out_program);
                        errors++;
                    end
                    if (out_ch.out_passed !== exp_r.pass) begin
                        $error("out_passed: expected %h actual %h",
                               exp_r.pass, out_ch.out_passed);
                        errors++;
                    end
                    if (out_ch.out_average !== exp_r.avg) begin
                        $error("out_average: expected %h actual %h",
                               exp_r.avg, out_ch.out_average);
                        errors++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                idle_cycles = 0;
                in_fired = 1'b1;
                r = '{t_func'(in_ch.func), in_ch.name_key, in_ch.program_code,
                      in_ch.passed_count, in_ch.grade_average, 1'b0};
                expected_replies.push_back(queue_reply(r));
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        logic [63:0] key_pool [8];
        int          pick;
        in_ch.valid         = 1'b0;
        in_ch.func          = FN_ENQ;
        in_ch.name_key      = '0;
        in_ch.program_code  = '0;
        in_ch.passed_count  = '0;
        in_ch.grade_average = '0;
        out_ch.ready        = 1'b0;
        errors = 0;
        idle_cycles = 0;
        gap_left = 0;
        stall_left = 0;
        quiet = 1'b0;
        long_hold_req = 1'b0;
        in_fired = 1'b0;
        shadow_head = 0;
        shadow_tail = 0;
        for (int i = 0; i < DEPTH; i++) shadow_mem[i] = '0;
        key_pool[0] = 64'd0;
        key_pool[1] = '1;
        for (int i = 2; i < 8; i++) key_pool[i] = {$urandom, $urandom};

        // Directed: empty cases, extremes, every operation.
        add_request(FN_DEQ,  64'd5, 16'd0, 8'd0, 14'd0, 1'b0);
        add_request(FN_LIN,  64'd5, 16'd0, 8'd0, 14'd0, 1'b0);
        add_request(FN_SORT, 64'd5, 16'd0, 8'd0, 14'd0, 1'b0);
        add_request(FN_ENQ,  '1, 16'hFFFF, 8'hFF, 14'h3FFF, 1'b0);
        add_request(FN_ENQ,  64'd0, 16'd0, 8'd0, 14'd10000, 1'b0);
        add_request(FN_ENQ,  64'h8000_0000_0000_0000, 16'h1234, 8'h55, 14'd0, 1'b0);
        add_request(FN_ENQ,  64'd0, 16'h7777, 8'hAA, 14'd9999, 1'b0);
        add_request(FN_LIN,  64'd0, 16'd0, 8'd0, 14'd0, 1'b0);
        add_request(FN_LIN,  64'h8000_0000_0000_0000, 16'd0, 8'd0, 14'd0, 1'b0);
        add_request(FN_LIN,  64'd42, 16'd0, 8'd0, 14'd0, 1'b0);
        add_request(FN_SORT, 64'h8000_0000_0000_0000, 16'd0, 8'd0, 14'd0, 1'b0);
        add_request(FN_SORT, 64'd42, 16'd0, 8'd0, 14'd0, 1'b0);
        add_request(FN_LIN,  '1, 16'd0, 8'd0, 14'd0, 1'b0);
        for (int i = 0; i < 5; i++) add_request(FN_DEQ, 64'd0, 16'd0, 8'd0, 14'd0, 1'b0);

        // Fill to capacity while the receiver holds off, then full cases.
        add_request(FN_ENQ, 64'd1000, 16'd1, 8'd1, 14'd1, 1'b1);
        for (int i = 1; i < DEPTH; i++) begin
            add_request(FN_ENQ, 64'd1000 - 64'(i), 16'($urandom), 8'($urandom),
                        14'($urandom_range(0, 10000)), 1'b0);
        end
        add_request(FN_ENQ,  64'd7, 16'd7, 8'd7, 14'd7, 1'b0);
        add_request(FN_LIN,  64'd1000 - 64'(DEPTH - 1), 16'd0, 8'd0, 14'd0, 1'b0);
        add_request(FN_DEQ,  64'd0, 16'd0, 8'd0, 14'd0, 1'b0);
        add_request(FN_ENQ,  64'd7, 16'd7, 8'd7, 14'd7, 1'b0);
        add_request(FN_SORT, 64'd1000, 16'd0, 8'd0, 14'd0, 1'b0);

        // Random: keys mostly from a small pool so that searches hit.
        for (int i = 0; i < 40; i++) begin
            pick = $urandom_range(0, 99);
            add_request(pick < 40 ? FN_ENQ : pick < 65 ? FN_DEQ : pick < 85 ? FN_LIN : FN_SORT,
                        $urandom_range(0, 3) == 0 ? {$urandom, $urandom}
                                                  : key_pool[$urandom_range(0, 7)],
                        16'($urandom), 8'($urandom), 14'($urandom), i == 20);
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // One long receiver hold-off while the fill sequence is offered.
        wait (pending_requests.size() < 170);
        @(negedge clk);
        long_hold_req = 1'b1;

        wait (pending_requests.size() < 20);
        quiet = 1'b1;
        wait (pending_requests.size() == 0);
        @(posedge clk);
        while (in_ch.valid) @(posedge clk);
        while (expected_replies.size() > 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0 && !out_ch.valid) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial rst_n = 1'b0;
endmodule

FILE: filelist.f
rtl/fqks_pkg.sv
rtl/fqks_if.sv
rtl/fqks_ram.sv
rtl/fqks_ctrl.sv
rtl/fifo_queue_with_key_search_unit.sv
test/tb_fifo_queue_with_key_search_unit.sv
